/* rtl/core/p7pad_pkg.sv */
// Package for the 16-byte block padding engine.
// Holds the field widths, the limits, the status and mode codes, and the
// command and status structs between controller and datapath. No dependencies.
package p7pad_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int BLOCK_LEN = 16;
  localparam int BLK_W     = $clog2(BLOCK_LEN);
  localparam int PAD_W     = BLK_W + 1;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // Largest message length that the byte counter may reach.
  localparam logic [LEN_W-1:0] MAX_LEN = 16'd65535;

  // Status codes carried on the end word.
  localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVF = 2'd2;

  // Mode register values.
  localparam logic MODE_PAD   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // Byte address of the mode register.
  localparam logic [ADDR_W-1:0] REG_MODE_ADDR = 3'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // accept the input word
    logic emit_end;  // load the end word (error or check result)
    logic load_pad;  // start the pad tail
    logic emit_pad;  // load one pad byte
    logic clear;     // return message state to its reset value
  } p7pad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
    logic pad_go;    // message end in pad mode needs a pad tail
    logic pad_last;  // the next pad byte is the final one
  } p7pad_sts_t;

endpackage

/* rtl/core/p7pad_in_if.sv */
// Input channel of the padding engine: valid, ready and one message word.
// Depends on p7pad_pkg.
interface p7pad_in_if;
  import p7pad_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              has_byte;
  logic              msg_end;

  modport source (output valid, data_byte, has_byte, msg_end, input ready);
  modport sink (input valid, data_byte, has_byte, msg_end, output ready);
endinterface

/* rtl/core/p7pad_out_if.sv */
// Output channel of the padding engine: valid, ready and one result word.
// Depends on p7pad_pkg.
interface p7pad_out_if;
  import p7pad_pkg::*;

  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_end;
  logic [LEN_W-1:0]    msg_length;
  logic [STATUS_W-1:0] status;

  modport source (output valid, out_byte, out_end, msg_length, status, input ready);
  modport sink (input valid, out_byte, out_end, msg_length, status, output ready);
endinterface

/* rtl/core/p7pad_ctrl.sv */
// Controller of the padding engine: accepts words, then sequences the end
// word or the pad tail. Depends on p7pad_pkg.
module p7pad_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_msg_end,
  output logic                  in_ready,
  input  p7pad_pkg::p7pad_sts_t sts,
  output p7pad_pkg::p7pad_cmd_t cmd
);
  import p7pad_pkg::*;

  localparam logic [1:0] S_ACCEPT = 2'd0;
  localparam logic [1:0] S_END    = 2'd1;
  localparam logic [1:0] S_PAD    = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Words enter only in the accept state and only when the output can take one.
  assign in_ready = (state == S_ACCEPT) && sts.out_free;

  // Next state and commands.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_ACCEPT: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (in_msg_end) begin
            state_next = S_END;
          end
        end
      end
      S_END: begin
        if (sts.out_free) begin
          if (sts.pad_go) begin
            cmd.load_pad = 1'b1;
            state_next   = S_PAD;
          end else begin
            cmd.emit_end = 1'b1;
            cmd.clear    = 1'b1;
            state_next   = S_ACCEPT;
          end
        end
      end
      S_PAD: begin
        if (sts.out_free) begin
          cmd.emit_pad = 1'b1;
          if (sts.pad_last) begin
            cmd.clear  = 1'b1;
            state_next = S_ACCEPT;
          end
        end
      end
      default: begin
        state_next = S_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // Every word loaded into the output register needs a free output slot.
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.take || cmd.emit_end || cmd.emit_pad) |-> sts.out_free)
    else $error("word issued while output register is occupied");

  // A message end always leads to the end-evaluation state.
  a_end_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && in_msg_end) |=> (state == S_END))
    else $error("message end not followed by end evaluation");

  // The message state is cleared only when the end word goes out.
  a_clear_with_end: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (cmd.emit_end || (cmd.emit_pad && sts.pad_last)))
    else $error("message cleared without an end word");

endmodule

/* rtl/core/p7pad_dp.sv */
// Datapath of the padding engine: byte counter, 16-byte tail window, pad
// counter, end checks and the output register. Depends on p7pad_pkg.
module p7pad_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           mode,
  input  logic [p7pad_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                           in_has_byte,
  input  p7pad_pkg::p7pad_cmd_t          cmd,
  output p7pad_pkg::p7pad_sts_t          sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [p7pad_pkg::BYTE_W-1:0]   out_byte,
  output logic                           out_end,
  output logic [p7pad_pkg::LEN_W-1:0]    msg_length,
  output logic [p7pad_pkg::STATUS_W-1:0] status
);
  import p7pad_pkg::*;

  logic [LEN_W-1:0]  count;
  logic              ovf;
  logic [BYTE_W-1:0] window [BLOCK_LEN];
  logic [PAD_W-1:0]  pad_left;

  logic [BYTE_W-1:0]   pad_chk;
  logic                chk_range_ok;
  logic                chk_eq_bad;
  logic [PAD_W-1:0]    pad_val;
  logic [LEN_W:0]      total;
  logic [STATUS_W-1:0] end_status;
  logic [LEN_W-1:0]    end_len;
  logic                pad_go;

  assign sts.out_free = !out_valid || out_ready;
  assign sts.pad_go   = pad_go;
  assign sts.pad_last = (pad_left == PAD_W'(1));

  // Check mode: the last byte gives the pad length; that many trailing bytes
  // must all equal it.
  assign pad_chk      = window[BLOCK_LEN-1];
  assign chk_range_ok = (pad_chk != '0) && (pad_chk <= BYTE_W'(BLOCK_LEN));
  always_comb begin
    chk_eq_bad = 1'b0;
    for (int i = 0; i < BLOCK_LEN; i++) begin
      if ((pad_chk >= BYTE_W'(BLOCK_LEN - i)) && (window[i] != pad_chk)) begin
        chk_eq_bad = 1'b1;
      end
    end
  end

  // Pad mode: pad length fills up to the next block boundary.
  assign pad_val = PAD_W'(BLOCK_LEN) - {1'b0, count[BLK_W-1:0]};
  assign total   = {1'b0, count} + (LEN_W+1)'(pad_val);

  // End word fields; overflow outranks every other error.
  always_comb begin
    end_status = STATUS_OK;
    end_len    = '0;
    pad_go     = 1'b0;
    if (ovf) begin
      end_status = STATUS_OVF;
    end else if (mode == MODE_CHECK) begin
      if ((count == '0) || (count[BLK_W-1:0] != '0)) begin
        end_status = STATUS_BAD;
      end else if (!chk_range_ok || chk_eq_bad) begin
        end_status = STATUS_BAD;
      end else if (count == LEN_W'(pad_chk)) begin
        end_status = STATUS_BAD;
      end else begin
        end_len = count - LEN_W'(pad_chk);
      end
    end else begin
      if (count == '0) begin
        end_status = STATUS_BAD;
      end else if (total > {1'b0, MAX_LEN}) begin
        end_status = STATUS_OVF;
      end else begin
        pad_go = 1'b1;
      end
    end
  end

  // Message state: counter, overflow flag and tail window.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      ovf   <= 1'b0;
      for (int i = 0; i < BLOCK_LEN; i++) begin
        window[i] <= '0;
      end
    end else if (cmd.take && in_has_byte) begin
      if (count >= MAX_LEN) begin
        ovf <= 1'b1;
      end else begin
        count <= count + LEN_W'(1);
      end
      for (int i = 0; i < BLOCK_LEN - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[BLOCK_LEN-1] <= in_data_byte;
    end
  end

  // Pad tail counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_left <= '0;
    end else if (cmd.load_pad) begin
      pad_left <= pad_val;
    end else if (cmd.emit_pad) begin
      pad_left <= pad_left - PAD_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.take && in_has_byte && (mode == MODE_PAD)) ||
                 cmd.emit_end || cmd.emit_pad) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && in_has_byte && (mode == MODE_PAD)) begin
      out_byte   <= in_data_byte;
      out_end    <= 1'b0;
      msg_length <= '0;
      status     <= STATUS_OK;
    end else if (cmd.emit_end) begin
      out_byte   <= '0;
      out_end    <= 1'b1;
      msg_length <= end_len;
      status     <= end_status;
    end else if (cmd.emit_pad) begin
      out_byte   <= BYTE_W'(pad_val);
      out_end    <= sts.pad_last;
      msg_length <= sts.pad_last ? total[LEN_W-1:0] : '0;
      status     <= STATUS_OK;
    end
  end

  // The overflow flag is only ever set with the counter at its limit.
  a_ovf_at_limit: assert property (@(posedge clk) disable iff (rst)
    ovf |-> (count == MAX_LEN))
    else $error("overflow flag set below the length limit");

  // A pad byte is only issued while pad bytes remain.
  a_pad_left: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_pad |-> (pad_left != '0))
    else $error("pad byte issued with no pad bytes left");

  // After a clear the message state is back at zero.
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> ((count == '0) && !ovf && (window[BLOCK_LEN-1] == '0)))
    else $error("message state not cleared");

endmodule

/* rtl/core/pkcs7_block16_pad_check.sv */
// Top level of the 16-byte block padding engine: mode register on the APB
// port, controller and datapath. Depends on p7pad_pkg, p7pad_in_if,
// p7pad_out_if, p7pad_ctrl and p7pad_dp.
//
// Usage: words enter on din (data_byte, has_byte, msg_end) and results leave
// on dout (out_byte, out_end, msg_length, status), both valid/ready.
// The mode register at byte address 0 selects pad mode (0) or check mode (1);
// write it only while the engine is idle.
// In pad mode each byte comes out in the cycle after it is accepted, and a word
// is taken every cycle while dout keeps up. After a message end item the
// engine enters end evaluation, which loads the end word for an error or in
// check mode; in pad mode the pad tail of 1 to 16 bytes then follows. In check
// mode bytes give no word; the end gives a single word, which end evaluation
// loads into the output register. No new item is taken during the end
// evaluation and the pad tail.
// Reset clears the mode, the byte counter, the tail window and the output
// valid flag. When dout stalls, the held word stays in the output register and
// din.ready drops until that word is taken; nothing is lost.
module pkcs7_block16_pad_check (
  input  logic                           clk,
  input  logic                           rst,
  p7pad_in_if.sink                       din,
  p7pad_out_if.source                    dout,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [p7pad_pkg::ADDR_W-1:0]   paddr,
  input  logic [p7pad_pkg::DATA_W-1:0]   pwdata,
  output logic [p7pad_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);
  import p7pad_pkg::*;

  logic       mode;
  p7pad_cmd_t cmd;
  p7pad_sts_t sts;

  // Configuration port: one mode register, zero wait states.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MODE_ADDR) ? DATA_W'(mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PAD;
    end else if (psel && penable && pwrite && pready && (paddr == REG_MODE_ADDR)) begin
      mode <= pwdata[0];
    end
  end

  // Controller.
  p7pad_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (din.valid),
    .in_msg_end (din.msg_end),
    .in_ready   (din.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath.
  p7pad_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .mode         (mode),
    .in_data_byte (din.data_byte),
    .in_has_byte  (din.has_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .out_byte     (dout.out_byte),
    .out_end      (dout.out_end),
    .msg_length   (dout.msg_length),
    .status       (dout.status)
  );

endmodule
